// File: rtl/kwhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhq_pkg: shared types and constants for the k-way merge heap
// Record layout, command and status codes, FSM states, and the hash byte
// mask used by the ordering compare.
// ----------------------------------------------------------------------------
package kwhq_pkg;

  // Heap geometry
  localparam int HEAP_DEPTH = 16;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = 5;
  localparam int HASH_NB    = 10;
  localparam int HASH_W     = 8 * HASH_NB;

  // One heap record
  typedef struct packed {
    logic [63:0] hash_upper;
    logic [15:0] hash_lower;
    logic [47:0] nonce;
    logic [3:0]  source;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_POP     = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RD_ROOT,
    S_RD_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DONE
  } state_t;

  // Keep the leading n hash bytes, clear the rest (n saturates at HASH_NB)
  function automatic logic [HASH_W-1:0] hash_mask(input logic [3:0] n);
    logic [HASH_W-1:0] m;
    m = '0;
    for (int b = 0; b < HASH_NB; b++) begin
      if (b < int'(n)) begin
        m[HASH_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/kway_heap_merge_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_heap_merge_queue: min-heap of merge records with push/replace/pop
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   command, hash, nonce, source
//   out_     output     out_valid/out_stall status, min record, occupancy
//   cfg_     input      cfg_wr_en           hash_bytes_compared
//
// One item at a time: the next item is taken only once the last result has
// moved to the output register. Errors and no-op go straight to the result.
// Sift-up steps through S_UP_CHK and S_UP_CMP per level, sift-down through
// S_DN_CHK, S_DN_L and S_DN_R (left read, right read, one compare each), set
// by the single RAM read port and the shared compare; replace on a full heap is
// the longest case. in_stall is high from acceptance until the result moves
// to the output register; a waiting result does not block the next item.
// Synchronous active-low reset empties the heap and sets the compare width
// to all ten hash bytes. RAM contents need no clearing.
// ----------------------------------------------------------------------------
module kway_heap_merge_queue
  import kwhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_hash_upper,
  input  logic [15:0] in_hash_lower,
  input  logic [47:0] in_nonce_in,
  input  logic [3:0]  in_source_in,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_min_hash_upper,
  output logic [15:0] out_min_hash_lower,
  output logic [47:0] out_min_nonce,
  output logic [3:0]  out_min_source,
  output logic [4:0]  out_occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HEAP_DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  cmd_t               cmd_r, cmd_nxt;
  rec_t               cur_r, cur_nxt;
  rec_t               alt_r, alt_nxt;
  logic               left_lt_r, left_lt_nxt;
  stat_t              res_status_r, res_status_nxt;
  rec_t               res_rec_r, res_rec_nxt;
  logic [HASH_W-1:0]  mask_r;
  logic               out_valid_r;
  stat_t              out_status_r;
  rec_t               out_rec_r;
  logic [CNT_W-1:0]   out_occ_r;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  rec_t               wr_data;
  logic [IDX_W-1:0]   rd_addr;
  rec_t               rd_data;
  rec_t               cmp_a, cmp_b;
  logic               cmp_lt;
  logic               in_acc;
  logic               out_load;
  logic [IDX_W-1:0]   parent;
  logic [CNT_W-1:0]   left5, right5, cnt_m1;
  rec_t               in_rec;
  logic [3:0]         cfg_sat;

  // Heap storage and shared compare
  kwhq_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (REC_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kwhq_cmp u_cmp (
    .rec_a  (cmp_a),
    .rec_b  (cmp_b),
    .mask   (mask_r),
    .a_less (cmp_lt)
  );

  // Index arithmetic
  assign parent = (idx_r - IDX_W'(1)) >> 1;
  assign left5  = {idx_r, 1'b1};
  assign right5 = left5 + CNT_W'(1);
  assign cnt_m1 = count_r - CNT_W'(1);

  assign in_rec = '{hash_upper: in_hash_upper, hash_lower: in_hash_lower,
                    nonce: in_nonce_in, source: in_source_in};

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Config register, saturated to ten bytes
  assign cfg_sat = (cfg_wr_data > 4'(HASH_NB)) ? 4'(HASH_NB) : cfg_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= hash_mask(4'(HASH_NB));
    end else if (cfg_wr_en) begin
      mask_r <= hash_mask(cfg_sat);
    end
  end

  // Sequencer: next state, RAM ports, compare operands
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    alt_nxt        = alt_r;
    left_lt_nxt    = left_lt_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = cur_r;
    rd_addr        = '0;
    cmp_a          = cur_r;
    cmp_b          = rd_data;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = cmd_t'(in_command);
          cur_nxt        = in_rec;
          res_rec_nxt    = '0;
          res_status_nxt = STAT_OK;
          idx_nxt        = '0;
          case (cmd_t'(in_command))
            CMD_PUSH: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = S_DONE;
              end else begin
                idx_nxt   = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_UP_CHK;
              end
            end
            CMD_REPLACE, CMD_POP: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RD_ROOT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Sift-up: hole moves toward the root
      S_UP_CHK: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = parent;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data;
          idx_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Root is the emitted minimum
      S_RD_ROOT: begin
        res_rec_nxt = rd_data;
        if (cmd_r == CMD_REPLACE) begin
          cur_nxt.source = rd_data.source;
          state_nxt      = S_DN_CHK;
        end else begin
          rd_addr   = cnt_m1[IDX_W-1:0];
          count_nxt = cnt_m1;
          state_nxt = S_RD_LAST;
        end
      end

      S_RD_LAST: begin
        cur_nxt   = rd_data;
        state_nxt = S_DN_CHK;
      end

      // Sift-down: hole moves toward the leaves
      S_DN_CHK: begin
        if (left5 >= count_r) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = left5[IDX_W-1:0];
          state_nxt = S_DN_L;
        end
      end

      S_DN_L: begin
        cmp_a       = rd_data;
        cmp_b       = cur_r;
        left_lt_nxt = cmp_lt;
        alt_nxt     = cmp_lt ? rd_data : cur_r;
        if (right5 < count_r) begin
          rd_addr   = right5[IDX_W-1:0];
          state_nxt = S_DN_R;
        end else if (cmp_lt) begin
          wr_en     = 1'b1;
          wr_data   = rd_data;
          idx_nxt   = left5[IDX_W-1:0];
          state_nxt = S_DN_CHK;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DN_R: begin
        cmp_a = rd_data;
        cmp_b = alt_r;
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data   = rd_data;
          idx_nxt   = right5[IDX_W-1:0];
          state_nxt = S_DN_CHK;
        end else if (left_lt_r) begin
          wr_data   = alt_r;
          idx_nxt   = left5[IDX_W-1:0];
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    alt_r        <= alt_nxt;
    left_lt_r    <= left_lt_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rec_r    <= res_rec_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_min_hash_upper = out_rec_r.hash_upper;
  assign out_min_hash_lower = out_rec_r.hash_lower;
  assign out_min_nonce      = out_rec_r.nonce;
  assign out_min_source     = out_rec_r.source;
  assign out_occupancy      = out_occ_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("heap count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) ||
                     (count_r == $past(count_r) + CNT_W'(1)) ||
                     (count_r + CNT_W'(1) == $past(count_r)))
    else $error("heap count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("heap write outside a command");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("result load did not return to idle");

endmodule

// File: rtl/kwhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhq_ram: heap record storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwhq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/kwhq_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhq_cmp: record ordering compare
// a < b on the masked hash bytes, ties broken by the nonce.
// ----------------------------------------------------------------------------
module kwhq_cmp
  import kwhq_pkg::*;
(
  input  rec_t              rec_a,
  input  rec_t              rec_b,
  input  logic [HASH_W-1:0] mask,
  output logic              a_less
);

  logic [HASH_W+47:0] key_a;
  logic [HASH_W+47:0] key_b;

  // Masked hash then nonce, as one big-endian key
  assign key_a  = {{rec_a.hash_upper, rec_a.hash_lower} & mask, rec_a.nonce};
  assign key_b  = {{rec_b.hash_upper, rec_b.hash_lower} & mask, rec_b.nonce};
  assign a_less = key_a < key_b;

endmodule
